### hw/rtl/lfpd_pkg.sv
// Shared types, constants and lookup functions for the line follower PD steering block.
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

  // Field widths
  localparam int unsigned PatternW = 5;
  localparam int unsigned RegW     = 15;
  localparam int unsigned PosW     = 12;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned CfgIdxW  = 3;

  // Datapath widths
  localparam int unsigned DerivW   = PosW + 1;          // error difference
  localparam int unsigned PropPrW  = RegW + 1 + PosW;   // signed gain times error
  localparam int unsigned DerivPrW = RegW + 1 + DerivW; // signed gain times difference
  localparam int unsigned PdSumW   = DerivPrW;          // sum of both products
  localparam int unsigned Q10Shift = 10;
  localparam int unsigned CorrW    = PdSumW - Q10Shift;
  localparam int unsigned SpeedW   = CorrW + 2;         // base plus or minus correction

  // Divide by three: floor(x * 43691 / 2^17) is exact for x below 2^17
  localparam int unsigned ThirdRecipW = 16;
  localparam int unsigned ThirdShift  = 17;
  localparam int unsigned ThirdProdW  = ThirdShift + RegW;
  localparam logic [ThirdRecipW-1:0] ThirdRecip = 16'd43691;

  // Special sensor patterns
  localparam logic [PatternW-1:0] PatLost       = 5'b00000;
  localparam logic [PatternW-1:0] PatOuterLeft  = 5'b00001;
  localparam logic [PatternW-1:0] PatLeftPair   = 5'b00011;
  localparam logic [PatternW-1:0] PatOuterRight = 5'b10000;
  localparam logic [PatternW-1:0] PatRightPair  = 5'b11000;
  localparam logic [PatternW-1:0] PatAllFive    = 5'b11111;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPropGain    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDerivGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCruiseSpeed = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpeedLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSearchSpeed = 3'd4;

  typedef struct packed {
    logic [RegW-1:0] prop_gain;
    logic [RegW-1:0] deriv_gain;
    logic [RegW-1:0] cruise_speed;
    logic [RegW-1:0] speed_limit;
    logic [RegW-1:0] search_speed;
  } lfpd_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_CORR,
    ST_DRIVE
  } lfpd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_pattern;
    logic calc_prod;
    logic calc_corr;
    logic load_result;
  } lfpd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } lfpd_status_t;

  // Weighted average of active sensors, truncated toward zero
  function automatic logic signed [PosW-1:0] lfpd_position(input logic [PatternW-1:0] pat);
    logic signed [PosW-1:0] pos;
    case (pat)
      5'd1:    pos = -12'sd2000;
      5'd2:    pos = -12'sd1000;
      5'd3:    pos = -12'sd1500;
      5'd5:    pos = -12'sd1000;
      5'd6:    pos = -12'sd500;
      5'd7:    pos = -12'sd1000;
      5'd8:    pos = 12'sd1000;
      5'd9:    pos = -12'sd500;
      5'd11:   pos = -12'sd666;
      5'd12:   pos = 12'sd500;
      5'd13:   pos = -12'sd333;
      5'd15:   pos = -12'sd500;
      5'd16:   pos = 12'sd2000;
      5'd18:   pos = 12'sd500;
      5'd19:   pos = -12'sd333;
      5'd20:   pos = 12'sd1000;
      5'd22:   pos = 12'sd333;
      5'd23:   pos = -12'sd250;
      5'd24:   pos = 12'sd1500;
      5'd25:   pos = 12'sd333;
      5'd26:   pos = 12'sd666;
      5'd28:   pos = 12'sd1000;
      5'd29:   pos = 12'sd250;
      5'd30:   pos = 12'sd500;
      default: pos = 12'sd0;
    endcase
    return pos;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/line_follow_pd_steering_top.sv
// Top level of the line follower PD steering block.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one 5-bit sensor pattern per
//   request, accepted at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i carry left and right drive,
//   line_found and line_position for each request.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (0 prop gain, 1 deriv gain, 2 cruise speed, 3 speed limit, 4 search
//   speed); other indexes are dropped. Write only while the block is idle.
// Timing:
//   The state machine steps through position/product, correction and drive
//   stages; the drive stage loads the result into the output register, and
//   no new request is taken before that.
//   The finished result sits in an output register; the next request is
//   accepted while it waits. If the receiver stalls, the following result
//   waits in the drive stage and in_stall_o stays high until it is taken.
// Reset:
//   rst_ni clears the configuration registers, the held error/position and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pd_steering_top import lfpd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [PatternW-1:0] sensor_pattern_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [DriveW-1:0] left_drive_o,
  output logic signed [DriveW-1:0] right_drive_o,
  output logic                     line_found_o,
  output logic signed [PosW-1:0]   line_position_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [RegW-1:0]     cfg_wdata_i
);

  lfpd_cfg_t    cfg;
  lfpd_cmd_t    cmd;
  lfpd_status_t status;

  lfpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lfpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfpd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .sensor_pattern_i (sensor_pattern_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_drive_o     (left_drive_o),
    .right_drive_o    (right_drive_o),
    .line_found_o     (line_found_o),
    .line_position_o  (line_position_o)
  );

  // An accepted request keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous request still in flight");

  // A new result only comes out of the busy drive stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

  // Lost-line spin drives the wheels in opposite directions at equal speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !line_found_o) |-> (left_drive_o == -right_drive_o))
    else $error("lost-line spin speeds do not mirror");

  // With the line in view both drives stay non-negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_found_o) |-> (!left_drive_o[DriveW-1] && !right_drive_o[DriveW-1]))
    else $error("negative drive while line is seen");

endmodule

`default_nettype wire

### hw/rtl/lfpd_cfg_regs.sv
// Configuration register bank for the line follower PD steering block.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_cfg_regs import lfpd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [RegW-1:0]    cfg_wdata_i,
  output lfpd_cfg_t               cfg_o
);

  lfpd_cfg_t cfg_q, cfg_d;

  // Decode the write; drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPropGain:    cfg_d.prop_gain    = cfg_wdata_i;
        CfgDerivGain:   cfg_d.deriv_gain   = cfg_wdata_i;
        CfgCruiseSpeed: cfg_d.cruise_speed = cfg_wdata_i;
        CfgSpeedLimit:  cfg_d.speed_limit  = cfg_wdata_i;
        CfgSearchSpeed: cfg_d.search_speed = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/lfpd_ctrl.sv
// Sequencing state machine for the line follower PD steering block.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_ctrl import lfpd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire lfpd_status_t status_i,
  output lfpd_cmd_t         cmd_o
);

  lfpd_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PROD;
      ST_PROD:  state_d = ST_CORR;
      ST_CORR:  state_d = ST_DRIVE;
      ST_DRIVE: if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o         = 1'b0;
        cmd_o.load_pattern = in_valid_i;
      end
      ST_PROD:  cmd_o.calc_prod   = 1'b1;
      ST_CORR:  cmd_o.calc_corr   = 1'b1;
      ST_DRIVE: cmd_o.load_result = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lfpd_datapath.sv
// Position lookup, PD correction and wheel speed datapath with result register.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_datapath import lfpd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lfpd_cfg_t           cfg_i,
  input  wire lfpd_cmd_t           cmd_i,
  output lfpd_status_t             status_o,
  input  wire logic [PatternW-1:0] sensor_pattern_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [DriveW-1:0] left_drive_o,
  output logic signed [DriveW-1:0] right_drive_o,
  output logic                     line_found_o,
  output logic signed [PosW-1:0]   line_position_o
);

  // Request being worked on
  logic [PatternW-1:0]        pattern_q;
  logic signed [PropPrW-1:0]  prop_prod_q;
  logic signed [DerivPrW-1:0] deriv_prod_q;
  logic [RegW-1:0]            third_q;
  logic signed [CorrW-1:0]    corr_q;

  // Last seen error; it is also the held position
  logic signed [PosW-1:0]     err_state_q;

  // Result register
  logic                       out_valid_q;
  logic signed [DriveW-1:0]   left_q, left_d;
  logic signed [DriveW-1:0]   right_q, right_d;
  logic                       found_q;

  logic signed [PosW-1:0]     err;
  logic signed [DerivW-1:0]   deriv;
  logic [ThirdProdW-1:0]      third_prod;
  logic signed [PdSumW-1:0]   pd_sum;
  logic signed [PdSumW-1:0]   pd_biased;
  logic signed [SpeedW-1:0]   cruise_ext;
  logic signed [SpeedW-1:0]   corr_ext;
  logic signed [SpeedW-1:0]   left_raw, right_raw;
  logic [RegW-1:0]            left_clamp, right_clamp;
  logic signed [DriveW-1:0]   search_pos, search_neg;
  logic                       found;

  // Capture the sensor pattern
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pattern) begin
      pattern_q <= sensor_pattern_i;
    end
  end

  // Products of gains with error and error difference, and a third of the cruise speed
  assign err        = lfpd_position(pattern_q);
  assign deriv      = DerivW'(err) - DerivW'(err_state_q);
  assign third_prod = ThirdProdW'(cfg_i.cruise_speed) * ThirdProdW'(ThirdRecip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_prod) begin
      prop_prod_q  <= PropPrW'($signed({1'b0, cfg_i.prop_gain})) * PropPrW'(err);
      deriv_prod_q <= DerivPrW'($signed({1'b0, cfg_i.deriv_gain})) * DerivPrW'(deriv);
      third_q      <= third_prod[ThirdShift +: RegW];
    end
  end

  // Sum and divide by 1024, rounding toward zero
  assign pd_sum    = PdSumW'(prop_prod_q) + deriv_prod_q;
  assign pd_biased = pd_sum + (pd_sum[PdSumW-1] ? PdSumW'((1 << Q10Shift) - 1) : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_corr) begin
      corr_q <= pd_biased[PdSumW-1:Q10Shift];
    end
  end

  // Wheel speeds around the cruise speed, clamped between zero and the limit
  assign cruise_ext = $signed({{(SpeedW-RegW){1'b0}}, cfg_i.cruise_speed});
  assign corr_ext   = SpeedW'(corr_q);
  assign left_raw   = cruise_ext + corr_ext;
  assign right_raw  = cruise_ext - corr_ext;

  always_comb begin
    if (left_raw < 0) begin
      left_clamp = '0;
    end else if (left_raw > $signed({{(SpeedW-RegW){1'b0}}, cfg_i.speed_limit})) begin
      left_clamp = cfg_i.speed_limit;
    end else begin
      left_clamp = left_raw[RegW-1:0];
    end
    if (right_raw < 0) begin
      right_clamp = '0;
    end else if (right_raw > $signed({{(SpeedW-RegW){1'b0}}, cfg_i.speed_limit})) begin
      right_clamp = cfg_i.speed_limit;
    end else begin
      right_clamp = right_raw[RegW-1:0];
    end
  end

  assign found      = (pattern_q != PatLost);
  assign search_pos = $signed({1'b0, cfg_i.search_speed});
  assign search_neg = -search_pos;

  // Pick the drive pair: lost-line spin, fixed overrides or PD result
  always_comb begin
    left_d  = $signed({1'b0, left_clamp});
    right_d = $signed({1'b0, right_clamp});
    if (!found) begin
      left_d  = err_state_q[PosW-1] ? search_neg : search_pos;
      right_d = err_state_q[PosW-1] ? search_pos : search_neg;
    end else if (pattern_q == PatOuterLeft || pattern_q == PatLeftPair) begin
      left_d  = $signed({1'b0, third_q});
      right_d = $signed({1'b0, cfg_i.speed_limit});
    end else if (pattern_q == PatOuterRight || pattern_q == PatRightPair) begin
      left_d  = $signed({1'b0, cfg_i.speed_limit});
      right_d = $signed({1'b0, third_q});
    end else if (pattern_q == PatAllFive) begin
      left_d  = $signed({2'b00, cfg_i.cruise_speed[RegW-1:1]});
      right_d = $signed({2'b00, cfg_i.cruise_speed[RegW-1:1]});
    end
  end

  // Hold the error; advance it only when the line is seen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_state_q <= '0;
    end else if (cmd_i.load_result && found) begin
      err_state_q <= err;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      left_q  <= left_d;
      right_q <= right_d;
      found_q <= found;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign left_drive_o    = left_q;
  assign right_drive_o   = right_q;
  assign line_found_o    = found_q;
  assign line_position_o = err_state_q;

endmodule

`default_nettype wire

### tb/tb_line_follow_pd_steering_top.sv
// Self-checking testbench for the line follower PD steering block: directed table, random phases.
`timescale 1ns / 1ps
module tb_line_follow_pd_steering_top;
  import lfpd_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 12;
  localparam int LongHold    = 40;
  localparam int PhaseItems  = 60;
  localparam int PhaseCount  = 8;
  localparam longint Q10Scale = 64'sd1 << Q10Shift;
  localparam int SensorWeight [PatternW] = '{-2000, -1000, 0, 1000, 2000};
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLastUnused  = 3'd7;

  typedef struct packed {
    logic signed [DriveW-1:0] left;
    logic signed [DriveW-1:0] right;
    logic                     found;
    logic signed [PosW-1:0]   pos;
  } steer_t;

  // One directed step: either a register write or a sensor request
  typedef struct packed {
    logic                is_write;
    logic [CfgIdxW-1:0]  idx;
    logic [RegW-1:0]     val;
    logic [PatternW-1:0] pat;
    logic                typed;
    steer_t              want;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [PatternW-1:0]      sensor_pattern_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DriveW-1:0] left_drive_o;
  logic signed [DriveW-1:0] right_drive_o;
  logic                     line_found_o;
  logic signed [PosW-1:0]   line_position_o;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [RegW-1:0]          cfg_wdata_i = '0;

  // Steering model: register copies and held line state
  int gain_p = 0, gain_d = 0, cruise = 0, limit = 0, search = 0;
  int last_err = 0, held_pos = 0;

  steer_t pending_steer[$];
  int     mismatch_count = 0;
  int     quiet_cycles = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;
  bit     hold_request = 1'b0;

  always #5 clk_i = ~clk_i;

  line_follow_pd_steering_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sensor_pattern_i(sensor_pattern_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_drive_o    (left_drive_o),
    .right_drive_o   (right_drive_o),
    .line_found_o    (line_found_o),
    .line_position_o (line_position_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  function automatic int clamp_wheel(input longint v);
    if (v < 0) return 0;
    if (v > longint'(limit)) return limit;
    return int'(v);
  endfunction

  // Work out wheel drives for one pattern and advance the held error
  function automatic steer_t steer_predict(input logic [PatternW-1:0] pat);
    int     sum;
    int     cnt;
    int     err;
    int     l;
    int     r;
    longint corr;
    steer_t res;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < PatternW; i++) begin
      if (pat[i]) begin
        sum += SensorWeight[i];
        cnt++;
      end
    end
    if (cnt == 0) begin
      // Line lost: spin toward the last error, keep state
      res.found = 1'b0;
      l = (last_err >= 0) ? search : -search;
      r = -l;
    end else begin
      err  = sum / cnt;
      corr = (longint'(gain_p) * err + longint'(gain_d) * (err - last_err)) / Q10Scale;
      res.found = 1'b1;
      held_pos  = err;
      last_err  = err;
      l = clamp_wheel(longint'(cruise) + corr);
      r = clamp_wheel(longint'(cruise) - corr);
      if (pat == PatOuterLeft || pat == PatLeftPair) begin
        l = cruise / 3;
        r = limit;
      end else if (pat == PatOuterRight || pat == PatRightPair) begin
        l = limit;
        r = cruise / 3;
      end else if (pat == PatAllFive) begin
        l = cruise / 2;
        r = cruise / 2;
      end
    end
    res.left  = DriveW'(l);
    res.right = DriveW'(r);
    res.pos   = PosW'(held_pos);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Write one register and mirror it in the model
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPropGain:    gain_p = int'(val);
      CfgDerivGain:   gain_d = int'(val);
      CfgCruiseSpeed: cruise = int'(val);
      CfgSpeedLimit:  limit  = int'(val);
      CfgSearchSpeed: search = int'(val);
      default: ;
    endcase
  endtask

  // Offer one request, hold it until taken, then queue its expected result
  task automatic send_pattern(input logic [PatternW-1:0] pat, input logic typed,
                              input steer_t want);
    steer_t calc;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    sensor_pattern_i <= pat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    calc = steer_predict(pat);
    pending_steer.push_back(typed ? want : calc);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = LongHold;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    steer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_steer.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = pending_steer.pop_front();
        if (left_drive_o !== want.left)
          report_mismatch($sformatf("left_drive %0d, expected %0d", left_drive_o, want.left));
        if (right_drive_o !== want.right)
          report_mismatch($sformatf("right_drive %0d, expected %0d", right_drive_o,
                                    want.right));
        if (line_found_o !== want.found)
          report_mismatch($sformatf("line_found %0b, expected %0b", line_found_o, want.found));
        if (line_position_o !== want.pos)
          report_mismatch($sformatf("line_position %0d, expected %0d", line_position_o,
                                    want.pos));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_line_follow_pd_steering_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t            dir_rows[$];
    logic [PatternW-1:0] pat;
    steer_t              none;
    none = '0;

    // Zero registers after reset: every drive reads zero
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatLost, 1'b1,
                                  steer_t'{16'sd0, 16'sd0, 1'b0, 12'sd0}});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatOuterLeft, 1'b1,
                                  steer_t'{16'sd0, 16'sd0, 1'b1, -12'sd2000}});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatLost, 1'b1,
                                  steer_t'{16'sd0, 16'sd0, 1'b0, -12'sd2000}});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatOuterRight, 1'b1,
                                  steer_t'{16'sd0, 16'sd0, 1'b1, 12'sd2000}});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatAllFive, 1'b1,
                                  steer_t'{16'sd0, 16'sd0, 1'b1, 12'sd0}});
    // Unused register indexes must be dropped
    dir_rows.push_back(dir_row_t'{1'b1, CfgFirstUnused, 15'h7FFF, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgLastUnused, 15'h5A5A, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b00100, 1'b1,
                                  steer_t'{16'sd0, 16'sd0, 1'b1, 12'sd0}});
    // Full search speed, line lost after a centered error
    dir_rows.push_back(dir_row_t'{1'b1, CfgSearchSpeed, 15'h7FFF, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatLost, 1'b1,
                                  steer_t'{16'sd32767, -16'sd32767, 1'b0, 12'sd0}});
    // Moderate gains: walk pair, single-sensor, multi-sensor and lost-line patterns
    dir_rows.push_back(dir_row_t'{1'b1, CfgPropGain, 15'd4096, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgDerivGain, 15'd2048, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgCruiseSpeed, 15'd12000, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgSpeedLimit, 15'd20000, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatLeftPair, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatRightPair, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b01000, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b00010, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b10101, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b01011, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b11010, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b00111, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b11100, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatLost, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b00110, 1'b0, none});
    // All registers at their maximum, full-swing errors
    dir_rows.push_back(dir_row_t'{1'b1, CfgPropGain, 15'h7FFF, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgDerivGain, 15'h7FFF, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgCruiseSpeed, 15'h7FFF, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b1, CfgSpeedLimit, 15'h7FFF, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatOuterLeft, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatOuterRight, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b00010, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b01000, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, PatAllFive, 1'b0, none});
    // Zero limit clamps every corrected drive
    dir_rows.push_back(dir_row_t'{1'b1, CfgSpeedLimit, 15'd0, '0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{1'b0, '0, '0, 5'b01100, 1'b0, none});

    // Hold reset, then release it on a falling clock edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_pattern(dir_rows[i].pat, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: new register set and idling mode per phase
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_results();
      if (ph == 1) begin
        write_reg(CfgPropGain, '1);
        write_reg(CfgDerivGain, '1);
        write_reg(CfgCruiseSpeed, '1);
        write_reg(CfgSpeedLimit, '1);
        write_reg(CfgSearchSpeed, '1);
      end else if (ph == 2) begin
        write_reg(CfgPropGain, '0);
        write_reg(CfgDerivGain, '0);
        write_reg(CfgCruiseSpeed, '0);
        write_reg(CfgSpeedLimit, '0);
        write_reg(CfgSearchSpeed, '0);
      end else if (ph == 6) begin
        write_reg(CfgPropGain, RegW'($urandom));
        write_reg(CfgDerivGain, RegW'($urandom));
        write_reg(CfgCruiseSpeed, RegW'($urandom));
        write_reg(CfgSpeedLimit, RegW'($urandom));
        write_reg(CfgSearchSpeed, RegW'($urandom));
      end else begin
        write_reg(CfgPropGain, RegW'($urandom_range(0, 4095)));
        write_reg(CfgDerivGain, RegW'($urandom_range(0, 16383)));
        write_reg(CfgCruiseSpeed, RegW'($urandom_range(0, 20000)));
        write_reg(CfgSpeedLimit, RegW'($urandom_range(10000, 32767)));
        write_reg(CfgSearchSpeed, RegW'($urandom));
      end
      if (ph % 2 == 1)
        write_reg(CfgIdxW'($urandom_range(CfgFirstUnused, CfgLastUnused)), RegW'($urandom));

      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase

      for (int n = 0; n < PhaseItems; n++) begin
        // Long receiver hold-off fills the block while requests keep coming
        if (ph == 4 && n == 20) hold_request = 1'b1;
        // Sender pause until the block is empty
        if (ph == 5 && n == 30) drain_results();
        if ($urandom_range(0, 9) < 7) begin
          pat = PatternW'($urandom_range(0, 31));
        end else begin
          case ($urandom_range(0, 5))
            0: pat = PatLost;
            1: pat = PatOuterLeft;
            2: pat = PatLeftPair;
            3: pat = PatOuterRight;
            4: pat = PatRightPair;
            default: pat = PatAllFive;
          endcase
        end
        send_pattern(pat, 1'b0, none);
      end
    end

    // Let the last results out, then watch for strays
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("tb_line_follow_pd_steering_top OK");
    else $display("tb_line_follow_pd_steering_top NOT OK");
    $finish;
  end

endmodule
